// ===== hdl/dds_pkg.sv =====
// dds_pkg: shared codes and types for the door drive supervisor
// operation codes, timeout defaults and the result struct passed from core to top
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

	// operation codes of an input item
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_OPEN  = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	// counter limits and register defaults
	localparam int unsigned TICK_W          = 16;
	localparam logic [TICK_W-1:0] TICK_MAX  = 16'hFFFF;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd230;

	// one result item as produced by the core
	typedef struct packed {
		logic [2:0] door_state;
		logic       state_changed;
		logic       press_button;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/dds_core.sv =====
// dds_core: door mode state machine, contact edge tracking and elapsed tick counter
// computes one result per item and updates state when the item advances
// depends on dds_pkg
`timescale 1ns / 1ps
`default_nettype none

module dds_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [1:0]                  op,
	input  wire logic                        level,
	input  wire logic [dds_pkg::TICK_W-1:0]  timeout,
	output dds_pkg::result_t                 res
);

	typedef enum logic [2:0] {
		MODE_CLOSED  = 3'd0,
		MODE_OPENING = 3'd1,
		MODE_OPEN    = 3'd2,
		MODE_CLOSING = 3'd3,
		MODE_RETRY   = 3'd4,
		MODE_ERROR   = 3'd5
	} mode_t;

	mode_t                       mode_q;
	mode_t                       mode_d;
	logic                        prev_contact_q;
	logic [dds_pkg::TICK_W-1:0]  elapsed_q;
	logic [dds_pkg::TICK_W-1:0]  elapsed_inc;
	logic [dds_pkg::TICK_W-1:0]  elapsed_d;
	logic                        expired;
	logic                        changed;
	logic                        press;

	// saturating tick count and timeout compare
	assign elapsed_inc = (elapsed_q != dds_pkg::TICK_MAX) ? elapsed_q + 16'd1 : elapsed_q;
	assign expired     = elapsed_inc > timeout;

	// next mode, change flag and button pulse
	always_comb begin
		mode_d    = mode_q;
		elapsed_d = elapsed_q;
		changed   = 1'b0;
		press     = 1'b0;
		case (op)
			dds_pkg::OP_TICK: begin
				elapsed_d = elapsed_inc;
				if (prev_contact_q && !level) begin
					mode_d  = MODE_CLOSED;
					changed = 1'b1;
				end else if (!prev_contact_q && level) begin
					mode_d  = MODE_OPENING;
					changed = 1'b1;
				end else if (expired && mode_q == MODE_OPENING) begin
					mode_d  = MODE_OPEN;
					changed = 1'b1;
				end else if (expired && mode_q == MODE_CLOSING) begin
					mode_d  = MODE_RETRY;
					changed = 1'b1;
					press   = 1'b1;
				end else if (expired && mode_q == MODE_RETRY) begin
					mode_d  = MODE_ERROR;
					changed = 1'b1;
				end
			end
			dds_pkg::OP_OPEN: begin
				press = (mode_q == MODE_CLOSED);
			end
			dds_pkg::OP_CLOSE: begin
				if (mode_q == MODE_OPEN || mode_q == MODE_ERROR) begin
					mode_d  = MODE_CLOSING;
					changed = 1'b1;
					press   = 1'b1;
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		if (changed) begin
			elapsed_d = '0;
		end
	end

	assign res.door_state    = mode_d;
	assign res.state_changed = changed;
	assign res.press_button  = press;

	// state registers, updated as the item moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_OPEN;
			prev_contact_q <= 1'b1;
			elapsed_q      <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
			if (op == dds_pkg::OP_TICK) begin
				prev_contact_q <= level;
			end
		end
	end

	// a pulse without a change only comes from an open request on a closed door
	a_press_open: assert property (@(posedge clk) disable iff (!arst_n)
		step && press && !changed |-> op == dds_pkg::OP_OPEN && mode_q == MODE_CLOSED)
		else $error("button pulse without a change outside an open request");

	// any transition clears the tick count
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && changed |=> elapsed_q == '0)
		else $error("elapsed count not cleared on transition");

	// a tick without a transition leaves a nonzero count
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && !changed && op == dds_pkg::OP_TICK |=> elapsed_q != '0)
		else $error("tick did not advance the elapsed count");

	// state holds while no item advances
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(elapsed_q) && $stable(prev_contact_q))
		else $error("door state moved without an item");

endmodule

`default_nettype wire

// ===== hdl/door_drive_supervisor_top.sv =====
// door_drive_supervisor_top: input stage, timeout register and result register
// around the door supervision core
// depends on dds_pkg and dds_core
// a result passes the input register and then the result register; out_ready low holds it in place
// throughput: one item per cycle; both stages move whenever the result register frees up
// the next item sees the mode, contact and count that the previous item left, updated at its edge
// reset: mode open, contact level high, count zero, timeout 230, both stages empty
`timescale 1ns / 1ps
`default_nettype none

module door_drive_supervisor_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic        contact_level,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [2:0]  door_state,
	output      logic        state_changed,
	output      logic        press_button
);

	logic [dds_pkg::TICK_W-1:0]  run_timeout_q;
	logic                        valid_s1;
	logic [1:0]                  op_s1;
	logic                        level_s1;
	logic                        out_valid_q;
	dds_pkg::result_t            res_q;
	dds_pkg::result_t            res;
	logic                        step;
	logic                        out_free;

	// handshake: result slot free, stage one advances into it
	assign out_free  = !out_valid_q || out_ready;
	assign step      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_timeout_q <= dds_pkg::TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			run_timeout_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= operation;
			level_s1 <= contact_level;
		end
	end

	dds_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.op      (op_s1),
		.level   (level_s1),
		.timeout (run_timeout_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign door_state    = res_q.door_state;
	assign state_changed = res_q.state_changed;
	assign press_button  = res_q.press_button;

endmodule

`default_nettype wire
